@@ rtl/hsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared constants, phase codes and helpers for the heat-stake press sequencer.
// ----------------------------------------------------------------------------
package hsp_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int REG_WIDTH   = 16;
	localparam int INDEX_WIDTH = 2;

	// Configuration register indexes.
	localparam logic [INDEX_WIDTH-1:0] REG_STEP_DELAY = 2'd0;
	localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd1;
	localparam logic [INDEX_WIDTH-1:0] REG_SECOND     = 2'd2;

	localparam logic [REG_WIDTH-1:0] STEP_DELAY_RESET = 16'd1700;
	localparam logic [REG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd100;
	localparam logic [REG_WIDTH-1:0] SECOND_RESET     = 16'd1000;

	// Sequencer phase codes.
	localparam logic [4:0] PH_IDLE  = 5'd0;
	localparam logic [4:0] PH_ODEB  = 5'd1;
	localparam logic [4:0] PH_OW1   = 5'd2;
	localparam logic [4:0] PH_OW2   = 5'd3;
	localparam logic [4:0] PH_READY = 5'd4;
	localparam logic [4:0] PH_CDEB  = 5'd5;
	localparam logic [4:0] PH_CW    = 5'd6;
	localparam logic [4:0] PH_SDEB  = 5'd7;
	localparam logic [4:0] PH_SW0   = 5'd8;
	localparam logic [4:0] PH_SW1   = 5'd9;
	localparam logic [4:0] PH_SW2   = 5'd10;
	localparam logic [4:0] PH_HEAT  = 5'd11;
	localparam logic [4:0] PH_SW4   = 5'd12;
	localparam logic [4:0] PH_SW5   = 5'd13;
	localparam logic [4:0] PH_SW6   = 5'd14;
	localparam logic [4:0] PH_HOLD  = 5'd15;
	localparam logic [4:0] PH_SW7   = 5'd16;
	localparam logic [4:0] PH_SW8   = 5'd17;

	// Station one actuator bits.
	localparam logic [6:0] A_Z       = 7'h01;
	localparam logic [6:0] A_CHEM    = 7'h02;
	localparam logic [6:0] A_HOLDIN  = 7'h04;
	localparam logic [6:0] A_HOLDOUT = 7'h08;
	localparam logic [6:0] A_EP2     = 7'h10;
	localparam logic [6:0] A_EP1     = 7'h20;
	localparam logic [6:0] A_HEATER  = 7'h40;

	// Station two actuator bits.
	localparam logic [5:0] B_HEATER  = 6'h01;
	localparam logic [5:0] B_EP1     = 6'h02;
	localparam logic [5:0] B_EP2     = 6'h04;
	localparam logic [5:0] B_HOLDOUT = 6'h08;
	localparam logic [5:0] B_HOLDIN  = 6'h10;
	localparam logic [5:0] B_CHEM    = 6'h20;

	localparam logic [2:0] POS_IDLE  = 3'd0;
	localparam logic [2:0] POS_FIRST = 3'd1;
	localparam logic [2:0] POS_OUT   = 3'd2;
	localparam logic [2:0] POS_IN    = 3'd3;
	localparam logic [2:0] POS_LAST  = 3'd4;

	localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

	// A target beyond the timer's range is cut to its largest count.
	function automatic logic [TIMER_WIDTH-1:0] timer_sat(input logic [REG_WIDTH-1:0] target);
		logic [31:0] wide;
		wide = 32'(target);
		if (wide > TIMER_MAX)
			wide = TIMER_MAX;
		return wide[TIMER_WIDTH-1:0];
	endfunction

endpackage

@@ rtl/hsp_if.sv @@
// ----------------------------------------------------------------------------
// hsp_in_if / hsp_out_if
// Valid/ready channels carrying press sample words and press result words.
// ----------------------------------------------------------------------------
interface hsp_in_if;
	logic       valid;
	logic       ready;
	logic       tick;
	logic       orient_btn;
	logic       clamp_btn;
	logic       emergency;
	logic       link_request;
	logic [7:0] time_setting;

	modport source (output valid, tick, orient_btn, clamp_btn, emergency, link_request,
		time_setting, input ready);
	modport sink (input valid, tick, orient_btn, clamp_btn, emergency, link_request,
		time_setting, output ready);
endinterface

interface hsp_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] m1_drive;
	logic [5:0] m2_drive;
	logic [2:0] clamp_step;
	logic       busy_res;
	logic       emergency_hold;

	modport source (output valid, m1_drive, m2_drive, clamp_step, busy_res, emergency_hold,
		input ready);
	modport sink (input valid, m1_drive, m2_drive, clamp_step, busy_res, emergency_hold,
		output ready);
endinterface

@@ rtl/heat_stake_press_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// heat_stake_press_sequencer_core
// Two-station heat-stake press sequencer: orient, clamp cycle, heat and hold.
// ----------------------------------------------------------------------------
// A sample word is held in the sample register, its result word in the result register.
// Throughput: one word per cycle while the result channel is not stalled; the
// sequencer state and timer update in a single pass between the two registers.
// Reset: arst_n clears the phase, timers, actuator bits and valid flags, and
// returns the configuration registers to their default values.
module heat_stake_press_sequencer_core
	import hsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [INDEX_WIDTH-1:0] cfg_index,
	input  logic [REG_WIDTH-1:0]   cfg_data,
	hsp_in_if.sink                 sample,
	hsp_out_if.source              result
);

	logic [REG_WIDTH-1:0] step_delay_q, debounce_q, second_q;

	logic       valid_s1;
	logic       tick_s1, ori_s1, clp_s1, emer_s1, link_s1;
	logic [7:0] ts_s1;

	logic [4:0]             phase_q, phase_n;
	logic [TIMER_WIDTH-1:0] wait_q, wait_n;
	logic [4:0]             secs_q, secs_n;
	logic [2:0]             pos_q, pos_n;
	logic                   link_q, link_n;
	logic [4:0]             heat_q, heat_n, hold_q, hold_n;
	logic [6:0]             st1_q, st1_n;
	logic [5:0]             st2_q, st2_n;

	logic                   out_valid_q;
	logic [6:0]             m1_q;
	logic [5:0]             m2_q;
	logic [2:0]             step_q;
	logic                   busy_q, ehold_q;

	logic                   advance;
	logic [REG_WIDTH-1:0]   target_raw;
	logic [TIMER_WIDTH-1:0] target;
	logic                   wait_end;
	logic [6:0]             set1, clr1;
	logic [5:0]             set2, clr2;
	logic                   busy_n;

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q <= STEP_DELAY_RESET;
			debounce_q   <= DEBOUNCE_RESET;
			second_q     <= SECOND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_DELAY: step_delay_q <= cfg_data;
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_SECOND:     second_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample.ready)
			valid_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			tick_s1 <= sample.tick;
			ori_s1  <= sample.orient_btn;
			clp_s1  <= sample.clamp_btn;
			emer_s1 <= sample.emergency;
			link_s1 <= sample.link_request;
			ts_s1   <= sample.time_setting;
		end
	end

	// Every wait shares one timer; the phase picks which length it runs against.
	always_comb begin
		case (phase_q)
			PH_ODEB, PH_CDEB, PH_SDEB: target_raw = debounce_q;
			PH_HEAT, PH_HOLD:          target_raw = second_q;
			default:                   target_raw = step_delay_q;
		endcase
	end

	assign target   = timer_sat(target_raw);
	assign wait_end = !emer_s1 && (wait_q >= target);

	always_comb begin
		phase_n = phase_q;
		wait_n  = wait_q;
		secs_n  = secs_q;
		pos_n   = pos_q;
		link_n  = link_q;
		heat_n  = heat_q;
		hold_n  = hold_q;
		set1    = '0;
		clr1    = '0;
		set2    = '0;
		clr2    = '0;

		if (!emer_s1 && !wait_end && tick_s1)
			wait_n = wait_q + TIMER_WIDTH'(1);

		case (phase_q)
			PH_ODEB: begin
				if (wait_end) begin
					wait_n = '0;
					if (ori_s1) begin
						pos_n   = POS_FIRST;
						set1    = A_Z | A_CHEM;
						set2    = B_CHEM;
						phase_n = PH_OW1;
					end else
						phase_n = PH_IDLE;
				end
			end
			PH_OW1: begin
				if (wait_end) begin
					set1    = A_EP1 | A_EP2;
					set2    = B_EP1 | B_EP2;
					wait_n  = '0;
					phase_n = PH_OW2;
				end
			end
			PH_OW2, PH_CW: begin
				if (wait_end) begin
					wait_n  = '0;
					phase_n = PH_READY;
				end
			end
			PH_READY: begin
				wait_n = wait_q;
				if (!emer_s1) begin
					if (clp_s1) begin
						wait_n  = '0;
						phase_n = PH_CDEB;
					end else if (ori_s1 && pos_q == POS_IN) begin
						wait_n  = '0;
						phase_n = PH_SDEB;
					end
				end
			end
			PH_CDEB: begin
				if (wait_end) begin
					wait_n = '0;
					if (clp_s1) begin
						phase_n = PH_CW;
						case (pos_q)
							POS_FIRST: begin
								pos_n = POS_OUT;
								set1  = A_HOLDOUT;
								set2  = B_HOLDOUT;
							end
							POS_OUT: begin
								pos_n = POS_IN;
								set1  = A_HOLDIN;
								set2  = B_HOLDIN;
							end
							POS_IN: begin
								pos_n = POS_LAST;
								clr1  = A_HOLDOUT;
								clr2  = B_HOLDOUT;
							end
							default: begin
								// Position zero, position four, or anything past it, wraps round to one.
								pos_n = POS_FIRST;
								clr1  = A_HOLDIN | A_HOLDOUT;
								clr2  = B_HOLDIN | B_HOLDOUT;
							end
						endcase
					end else
						phase_n = PH_READY;
				end
			end
			PH_SDEB: begin
				if (wait_end) begin
					wait_n = '0;
					if (ori_s1 && pos_q == POS_IN) begin
						clr1    = A_EP1 | A_EP2;
						clr2    = B_EP1 | B_EP2;
						phase_n = PH_SW0;
					end else
						phase_n = PH_READY;
				end
			end
			PH_SW0: begin
				if (wait_end) begin
					clr1    = A_CHEM;
					clr2    = B_CHEM;
					wait_n  = '0;
					phase_n = PH_SW1;
				end
			end
			PH_SW1: begin
				if (wait_end) begin
					set1    = A_HEATER;
					set2    = B_HEATER;
					wait_n  = '0;
					phase_n = PH_SW2;
				end
			end
			PH_SW2: begin
				if (wait_end) begin
					set1    = A_EP1 | A_EP2;
					set2    = B_EP1 | B_EP2;
					secs_n  = heat_q;
					wait_n  = '0;
					phase_n = PH_HEAT;
				end
			end
			PH_HEAT, PH_HOLD: begin
				if (secs_q == 5'd0) begin
					wait_n  = '0;
					phase_n = (phase_q == PH_HEAT) ? PH_SW4 : PH_SW7;
					if (phase_q == PH_HEAT) begin
						clr1 = A_EP1 | A_EP2;
						clr2 = B_EP1 | B_EP2;
					end else begin
						clr1 = A_HOLDOUT | A_HOLDIN;
						clr2 = B_HOLDOUT | B_HOLDIN;
					end
				end else if (wait_end) begin
					secs_n = secs_q - 5'd1;
					wait_n = '0;
				end
			end
			PH_SW4: begin
				if (wait_end) begin
					clr1    = A_HEATER;
					clr2    = B_HEATER;
					wait_n  = '0;
					phase_n = PH_SW5;
				end
			end
			PH_SW5: begin
				if (wait_end) begin
					set1    = A_EP1 | A_EP2;
					set2    = B_EP1 | B_EP2;
					wait_n  = '0;
					phase_n = PH_SW6;
				end
			end
			PH_SW6: begin
				if (wait_end) begin
					secs_n  = hold_q;
					wait_n  = '0;
					phase_n = PH_HOLD;
				end
			end
			PH_SW7: begin
				if (wait_end) begin
					clr1    = A_EP1 | A_EP2 | A_Z;
					clr2    = B_EP1 | B_EP2;
					wait_n  = '0;
					phase_n = PH_SW8;
				end
			end
			PH_SW8: begin
				if (wait_end) begin
					pos_n   = POS_IDLE;
					wait_n  = '0;
					phase_n = PH_IDLE;
				end
			end
			default: begin
				// Idle, and any code that means nothing, behaves as idle.
				phase_n = PH_IDLE;
				wait_n  = wait_q;
				if (!emer_s1) begin
					hold_n = {ts_s1[3:0], 1'b0};
					heat_n = {ts_s1[7:4], 1'b0};
					link_n = link_s1;
					if (ori_s1) begin
						wait_n  = '0;
						phase_n = PH_ODEB;
					end
				end
			end
		endcase

		st1_n = (st1_q & ~clr1) | set1;
		st2_n = link_q ? ((st2_q & ~clr2) | set2) : st2_q;
	end

	assign busy_n = !(phase_n == PH_IDLE || phase_n == PH_READY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_q  <= '0;
			secs_q  <= '0;
			pos_q   <= POS_IDLE;
			link_q  <= 1'b0;
			heat_q  <= '0;
			hold_q  <= '0;
			st1_q   <= '0;
			st2_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			wait_q  <= wait_n;
			secs_q  <= secs_n;
			pos_q   <= pos_n;
			link_q  <= link_n;
			heat_q  <= heat_n;
			hold_q  <= hold_n;
			st1_q   <= st1_n;
			st2_q   <= st2_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m1_q    <= st1_n;
			m2_q    <= st2_n;
			step_q  <= pos_n;
			busy_q  <= busy_n;
			ehold_q <= busy_n && emer_s1;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.m1_drive       = m1_q;
	assign result.m2_drive       = m2_q;
	assign result.clamp_step     = step_q;
	assign result.busy_res       = busy_q;
	assign result.emergency_hold = ehold_q;

endmodule

@@ sim/heat_stake_press_sequencer_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heat_stake_press_sequencer_core_tb
// Drives press sample words into the sequencer and checks every result word
// against a cycle-accurate prediction of phases, timers and actuator bits.
// Stimulus is mostly guided press cycles (orient, clamp steps, heat and hold)
// with random ticks, emergencies and time settings, mixed with random noise.
// ----------------------------------------------------------------------------
module heat_stake_press_sequencer_core_tb;
	import hsp_pkg::*;

	localparam logic [INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CAP       = 4000;
	localparam int GUIDED_EMER    = 4;
	localparam int NOISE_EMER     = 10;

	typedef struct packed {
		logic       tick;
		logic       orient_btn;
		logic       clamp_btn;
		logic       emergency;
		logic       link_request;
		logic [7:0] time_setting;
	} press_sample_t;

	typedef struct packed {
		logic [6:0] m1_drive;
		logic [5:0] m2_drive;
		logic [2:0] clamp_step;
		logic       busy_res;
		logic       emergency_hold;
	} press_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [INDEX_WIDTH-1:0] cfg_index;
	logic [REG_WIDTH-1:0]   cfg_data;

	hsp_in_if  sample_ch();
	hsp_out_if result_ch();

	heat_stake_press_sequencer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// Predicted sequencer state and register copies.
	logic [4:0]             phase_q;
	logic [TIMER_WIDTH-1:0] wait_q;
	logic [4:0]             secs_q;
	logic [2:0]             pos_q;
	logic                   link_q;
	logic [4:0]             heat_q;
	logic [4:0]             hold_q;
	logic [6:0]             st1_q;
	logic [5:0]             st2_q;
	logic [REG_WIDTH-1:0]   step_cfg;
	logic [REG_WIDTH-1:0]   deb_cfg;
	logic [REG_WIDTH-1:0]   sec_cfg;

	press_result_t expected_drive_q[$];
	int send_idle_pct;
	int recv_idle_pct;
	int sent_count;
	int fail_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- prediction

	function automatic bit wait_over(input logic [REG_WIDTH-1:0] target, input bit tk, em);
		logic [31:0] limit;
		limit = (32'(target) > TIMER_MAX) ? TIMER_MAX : 32'(target);
		if (em)
			return 1'b0;
		if (32'(wait_q) >= limit)
			return 1'b1;
		if (tk)
			wait_q = wait_q + 1'b1;
		return 1'b0;
	endfunction

	function automatic void drive_bits(input logic [6:0] a, input logic [5:0] b, input bit on);
		if (on) begin
			st1_q = st1_q | a;
			if (link_q)
				st2_q = st2_q | b;
		end else begin
			st1_q = st1_q & ~a;
			if (link_q)
				st2_q = st2_q & ~b;
		end
	endfunction

	function automatic void enter(input logic [4:0] ph);
		phase_q = ph;
		wait_q  = '0;
	endfunction

	function automatic bit seconds_over(input bit tk, em);
		if (secs_q == 5'd0)
			return 1'b1;
		if (wait_over(sec_cfg, tk, em)) begin
			secs_q = secs_q - 5'd1;
			wait_q = '0;
		end
		return 1'b0;
	endfunction

	function automatic press_result_t next_press_outputs(input press_sample_t s);
		press_result_t r;
		bit tk;
		bit em;
		bit busy;
		tk = s.tick;
		em = s.emergency;
		case (phase_q)
			PH_ODEB: begin
				if (wait_over(deb_cfg, tk, em)) begin
					if (s.orient_btn) begin
						pos_q = POS_FIRST;
						drive_bits(A_Z | A_CHEM, B_CHEM, 1'b1);
						enter(PH_OW1);
					end else
						enter(PH_IDLE);
				end
			end
			PH_OW1: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b1);
					enter(PH_OW2);
				end
			end
			PH_OW2: begin
				if (wait_over(step_cfg, tk, em))
					enter(PH_READY);
			end
			PH_READY: begin
				// The clamp button has priority over the orient button.
				if (!em) begin
					if (s.clamp_btn)
						enter(PH_CDEB);
					else if (s.orient_btn && pos_q == POS_IN)
						enter(PH_SDEB);
				end
			end
			PH_CDEB: begin
				if (wait_over(deb_cfg, tk, em)) begin
					if (s.clamp_btn) begin
						pos_q = (pos_q >= POS_LAST) ? POS_FIRST : pos_q + 3'd1;
						if (pos_q == POS_FIRST)
							drive_bits(A_HOLDIN | A_HOLDOUT, B_HOLDIN | B_HOLDOUT, 1'b0);
						else if (pos_q == POS_OUT)
							drive_bits(A_HOLDOUT, B_HOLDOUT, 1'b1);
						else if (pos_q == POS_IN)
							drive_bits(A_HOLDIN, B_HOLDIN, 1'b1);
						else
							drive_bits(A_HOLDOUT, B_HOLDOUT, 1'b0);
						enter(PH_CW);
					end else
						enter(PH_READY);
				end
			end
			PH_CW: begin
				if (wait_over(step_cfg, tk, em))
					enter(PH_READY);
			end
			PH_SDEB: begin
				if (wait_over(deb_cfg, tk, em)) begin
					if (s.orient_btn && pos_q == POS_IN) begin
						drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b0);
						enter(PH_SW0);
					end else
						enter(PH_READY);
				end
			end
			PH_SW0: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_CHEM, B_CHEM, 1'b0);
					enter(PH_SW1);
				end
			end
			PH_SW1: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_HEATER, B_HEATER, 1'b1);
					enter(PH_SW2);
				end
			end
			PH_SW2: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b1);
					secs_q = heat_q;
					enter(PH_HEAT);
				end
			end
			PH_HEAT: begin
				if (seconds_over(tk, em)) begin
					drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b0);
					enter(PH_SW4);
				end
			end
			PH_SW4: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_HEATER, B_HEATER, 1'b0);
					enter(PH_SW5);
				end
			end
			PH_SW5: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b1);
					enter(PH_SW6);
				end
			end
			PH_SW6: begin
				if (wait_over(step_cfg, tk, em)) begin
					secs_q = hold_q;
					enter(PH_HOLD);
				end
			end
			PH_HOLD: begin
				if (seconds_over(tk, em)) begin
					drive_bits(A_HOLDOUT | A_HOLDIN, B_HOLDOUT | B_HOLDIN, 1'b0);
					enter(PH_SW7);
				end
			end
			PH_SW7: begin
				if (wait_over(step_cfg, tk, em)) begin
					drive_bits(A_EP1 | A_EP2, B_EP1 | B_EP2, 1'b0);
					drive_bits(A_Z, 6'h00, 1'b0);
					enter(PH_SW8);
				end
			end
			PH_SW8: begin
				if (wait_over(step_cfg, tk, em)) begin
					pos_q = POS_IDLE;
					enter(PH_IDLE);
				end
			end
			default: begin
				phase_q = PH_IDLE;
				// Settings latch only while no emergency is active.
				if (!em) begin
					hold_q = {s.time_setting[3:0], 1'b0};
					heat_q = {s.time_setting[7:4], 1'b0};
					link_q = s.link_request;
					if (s.orient_btn)
						enter(PH_ODEB);
				end
			end
		endcase
		busy = !(phase_q == PH_IDLE || phase_q == PH_READY);
		r.m1_drive       = st1_q;
		r.m2_drive       = st2_q;
		r.clamp_step     = pos_q;
		r.busy_res       = busy;
		r.emergency_hold = busy && em;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic press_sample_t mk(input bit tk, ori, clp, em, lnk,
		input logic [7:0] ts);
		press_sample_t s;
		s.tick         = tk;
		s.orient_btn   = ori;
		s.clamp_btn    = clp;
		s.emergency    = em;
		s.link_request = lnk;
		s.time_setting = ts;
		return s;
	endfunction

	// Random content; small time settings are favoured to keep heat and hold short.
	function automatic press_sample_t random_sample(input bit ori, clp, input int emer_pct);
		logic [7:0] ts;
		if ($urandom_range(0, 1))
			ts = 8'($urandom_range(0, 255));
		else
			ts = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))};
		return mk($urandom_range(0, 9) < 7, ori, clp, $urandom_range(0, 99) < emer_pct,
			$urandom_range(0, 1), ts);
	endfunction

	task automatic send_sample(input press_sample_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.tick         <= s.tick;
		sample_ch.orient_btn   <= s.orient_btn;
		sample_ch.clamp_btn    <= s.clamp_btn;
		sample_ch.emergency    <= s.emergency;
		sample_ch.link_request <= s.link_request;
		sample_ch.time_setting <= s.time_setting;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		expected_drive_q.push_back(next_press_outputs(s));
		sent_count++;
	endtask

	// Registers are only written once every outstanding result word has drained.
	task automatic load_config(input logic [REG_WIDTH-1:0] step_v, deb_v, sec_v);
		logic [INDEX_WIDTH-1:0] idx [4];
		logic [REG_WIDTH-1:0]   val [4];
		idx[0] = REG_STEP_DELAY;
		idx[1] = REG_DEBOUNCE;
		idx[2] = REG_SECOND;
		idx[3] = REG_UNUSED;
		val[0] = step_v;
		val[1] = deb_v;
		val[2] = sec_v;
		val[3] = 16'($urandom_range(0, 65535));
		sample_ch.valid <= 1'b0;
		while (expected_drive_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		step_cfg = step_v;
		deb_cfg  = deb_v;
		sec_cfg  = sec_v;
	endtask

	// Holds the buttons until the predicted phase hits a stop phase or HOLD_CAP.
	task automatic hold_until(input bit ori, clp, input logic [4:0] stop_a, stop_b);
		int n;
		n = 0;
		while (phase_q != stop_a && phase_q != stop_b && n < HOLD_CAP) begin
			send_sample(random_sample(ori, clp, GUIDED_EMER));
			n++;
		end
	endtask

	task automatic clamp_press(input bit with_orient);
		hold_until(with_orient, 1'b1, PH_CW, PH_CW);
		hold_until(1'b0, 1'b0, PH_READY, PH_READY);
	endtask

	task automatic run_press_cycle(input int clamps);
		hold_until(1'b0, 1'b0, PH_IDLE, PH_READY);
		if (phase_q == PH_IDLE) begin
			repeat ($urandom_range(1, 4))
				send_sample(random_sample(1'b0, 1'b0, GUIDED_EMER));
			hold_until(1'b1, 1'b0, PH_OW1, PH_OW1);
			hold_until(1'b0, 1'b0, PH_READY, PH_READY);
		end
		repeat (clamps)
			clamp_press($urandom_range(0, 2) == 0);
		while (pos_q != POS_IN)
			clamp_press(1'b0);
		hold_until(1'b1, 1'b0, PH_SW0, PH_SW0);
		hold_until(1'b0, 1'b0, PH_IDLE, PH_IDLE);
	endtask

	task automatic noise_burst(input int count);
		repeat (count)
			send_sample(random_sample($urandom_range(0, 9) < 3, $urandom_range(0, 9) < 3,
				NOISE_EMER));
	endtask

	// ---------------------------------------------------------------- tests

	// Idle latching, ignored buttons and a frozen debounce at reset settings.
	task automatic test_idle_latch();
		send_sample(mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF));
		send_sample(mk(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00));
		send_sample(mk(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
		send_sample(mk(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'hA5));
		send_sample(mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h5A));
		send_sample(mk(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF));
		send_sample(mk(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h0F));
		send_sample(mk(0, 1'b1, 1'b0, 1'b0, 1'b0, 8'hF0));
	endtask

	// Zero-length waits and zero second length, with a clamp cycle that wraps.
	task automatic test_zero_waits();
		load_config(16'd0, 16'd0, 16'd0);
		run_press_cycle(6);
	endtask

	task automatic test_extreme_delays();
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		noise_burst(24);
		load_config(16'd1, 16'd1, 16'd1);
		run_press_cycle(2);
	endtask

	task automatic test_random_traffic(input int send_pct, recv_pct, quota);
		int target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = sent_count + quota;
		while (sent_count < target) begin
			if ($urandom_range(0, 3) == 0)
				load_config(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
					16'($urandom_range(1, 3)));
			if ($urandom_range(0, 3) == 0)
				noise_burst($urandom_range(10, 40));
			else
				run_press_cycle($urandom_range(1, 6));
		end
	endtask

	// ---------------------------------------------------------------- checking

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		press_result_t exp_w;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_drive_q.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					exp_w = expected_drive_q.pop_front();
					if (result_ch.m1_drive !== exp_w.m1_drive) begin
						$error("m1_drive expected %h actual %h", exp_w.m1_drive,
							result_ch.m1_drive);
						fail_count++;
					end
					if (result_ch.m2_drive !== exp_w.m2_drive) begin
						$error("m2_drive expected %h actual %h", exp_w.m2_drive,
							result_ch.m2_drive);
						fail_count++;
					end
					if (result_ch.clamp_step !== exp_w.clamp_step) begin
						$error("clamp_step expected %0d actual %0d", exp_w.clamp_step,
							result_ch.clamp_step);
						fail_count++;
					end
					if (result_ch.busy_res !== exp_w.busy_res) begin
						$error("busy_res expected %b actual %b", exp_w.busy_res,
							result_ch.busy_res);
						fail_count++;
					end
					if (result_ch.emergency_hold !== exp_w.emergency_hold) begin
						$error("emergency_hold expected %b actual %b", exp_w.emergency_hold,
							result_ch.emergency_hold);
						fail_count++;
					end
				end
			end
		end
	end

	// Ends the run if no word moves on either channel for too long.
	initial begin
		int stall;
		stall = 0;
		while (stall < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = REG_STEP_DELAY;
		cfg_data               = '0;
		sample_ch.valid        = 1'b0;
		sample_ch.tick         = 1'b0;
		sample_ch.orient_btn   = 1'b0;
		sample_ch.clamp_btn    = 1'b0;
		sample_ch.emergency    = 1'b0;
		sample_ch.link_request = 1'b0;
		sample_ch.time_setting = '0;
		send_idle_pct = 20;
		recv_idle_pct = 79;
		sent_count    = 0;
		fail_count    = 0;
		phase_q  = PH_IDLE;
		wait_q   = '0;
		secs_q   = '0;
		pos_q    = POS_IDLE;
		link_q   = 1'b0;
		heat_q   = '0;
		hold_q   = '0;
		st1_q    = '0;
		st2_q    = '0;
		step_cfg = STEP_DELAY_RESET;
		deb_cfg  = DEBOUNCE_RESET;
		sec_cfg  = SECOND_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_latch();
		test_zero_waits();
		test_extreme_delays();
		test_random_traffic(20, 79, 520);
		test_random_traffic(79, 20, 520);
		test_random_traffic(0, 0, 520);

		sample_ch.valid <= 1'b0;
		while (expected_drive_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
